// ----- rtl/gaa_pkg.sv -----
package gaa_pkg;

  // sensor lanes: four gas or heat sensors plus the ir obstruction sensor
  localparam int unsigned NumSensors = 5;
  localparam int unsigned NumGas     = 4;
  localparam int unsigned MaskWidth  = 5;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned IdxWidth   = 3;

  // alarm needs this many gas triggers when co alone does not fire
  localparam int unsigned MultiCount = 2;
  // hold time after reset
  localparam int unsigned HoldReset  = 10;

  // lane positions inside the trigger mask
  localparam int unsigned LaneCo = 0;
  localparam int unsigned LaneIr = 4;

  // configuration register indexes
  typedef enum logic [IdxWidth-1:0] {
    REG_CO_THRESHOLD    = 3'd0,
    REG_CO2_THRESHOLD   = 3'd1,
    REG_SMOKE_THRESHOLD = 3'd2,
    REG_TEMP_THRESHOLD  = 3'd3,
    REG_IR_THRESHOLD    = 3'd4,
    REG_HOLD_TICKS      = 3'd5
  } cfg_reg_e;

  // led commands, also the remembered display pattern
  typedef enum logic [1:0] {
    LED_NONE = 2'd0,
    LED_WARN = 2'd1,
    LED_FULL = 2'd2,
    LED_OFF  = 2'd3
  } led_cmd_e;

  // one result item
  typedef struct packed {
    logic                 alarm_on;
    logic                 warning_on;
    logic                 obstructed_on;
    logic [MaskWidth-1:0] trigger_mask;
    led_cmd_e             led_command;
  } gaa_result_t;

endpackage

// ----- rtl/gas_alarm_aggregator_unit.sv -----
// channel   direction  handshake                payload
// in        request    in_valid_i / in_ready_o    co, co2, smoke, temp, ir levels
// out       result     out_valid_o / out_ready_i  alarm, warning, obstructed, mask, led
// cfg       write      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one request per cycle while in_ready_o is high: five compare lanes and the merge
// logic settle in the accept cycle; the result is registered (output or skid entry).
// a two-entry output buffer (output register plus skid) keeps in_ready_o high
// while one result waits; ready drops only when both entries are full.
// reset clears latches, hold counter, display memory and thresholds, and loads
// hold_ticks with ten.
module gas_alarm_aggregator_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned HOLD_WIDTH   = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [gaa_pkg::IdxWidth-1:0]       cfg_index_i,
  input  logic [((SAMPLE_WIDTH > HOLD_WIDTH) ? SAMPLE_WIDTH : HOLD_WIDTH)-1:0] cfg_data_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]            co_level_i,
  input  logic [SAMPLE_WIDTH-1:0]            co2_level_i,
  input  logic [SAMPLE_WIDTH-1:0]            smoke_level_i,
  input  logic [SAMPLE_WIDTH-1:0]            temp_level_i,
  input  logic [SAMPLE_WIDTH-1:0]            ir_level_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               alarm_on_o,
  output logic                               warning_on_o,
  output logic                               obstructed_on_o,
  output logic [gaa_pkg::MaskWidth-1:0]      trigger_mask_o,
  output logic [1:0]                         led_command_o
);

  logic [SAMPLE_WIDTH-1:0]          threshold_q [gaa_pkg::NumSensors];
  logic [HOLD_WIDTH-1:0]            hold_ticks_q;
  logic [SAMPLE_WIDTH-1:0]          level [gaa_pkg::NumSensors];
  logic [gaa_pkg::MaskWidth-1:0]    trig_mask;
  logic                             in_acc;
  gaa_pkg::gaa_result_t             result;
  gaa_pkg::gaa_result_t             out_q;
  gaa_pkg::gaa_result_t             skid_q;
  logic                             out_valid_q;
  logic                             skid_valid_q;
  logic                             pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gaa_pkg::NumSensors; i++) begin
        threshold_q[i] <= '0;
      end
      hold_ticks_q <= HOLD_WIDTH'(gaa_pkg::HoldReset);
    end else if (cfg_we_i) begin
      priority if (cfg_index_i == gaa_pkg::REG_HOLD_TICKS) begin
        hold_ticks_q <= cfg_data_i[HOLD_WIDTH-1:0];
      end else if (cfg_index_i <= gaa_pkg::REG_IR_THRESHOLD) begin
        threshold_q[cfg_index_i] <= cfg_data_i[SAMPLE_WIDTH-1:0];
      end else begin
        hold_ticks_q <= hold_ticks_q;
      end
    end
  end

  // sensor readings in lane order
  assign level[0] = co_level_i;
  assign level[1] = co2_level_i;
  assign level[2] = smoke_level_i;
  assign level[3] = temp_level_i;
  assign level[4] = ir_level_i;

  // compare lanes
  for (genvar g = 0; g < gaa_pkg::NumSensors; g++) begin : g_lane
    gaa_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_lane (
      .level_i    (level[g]),
      .threshold_i(threshold_q[g]),
      .trigger_o  (trig_mask[g])
    );
  end

  assign in_ready_o = !skid_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // merge of lane triggers into latches and led command
  gaa_merge #(
    .HOLD_WIDTH(HOLD_WIDTH)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .update_i      (in_acc),
    .hold_ticks_i  (hold_ticks_q),
    .trigger_mask_i(trig_mask),
    .result_o      (result)
  );

  assign pop = out_valid_q && out_ready_i;

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_acc) begin
      skid_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign alarm_on_o      = out_q.alarm_on;
  assign warning_on_o    = out_q.warning_on;
  assign obstructed_on_o = out_q.obstructed_on;
  assign trigger_mask_o  = out_q.trigger_mask;
  assign led_command_o   = out_q.led_command;

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  // every accepted request leaves a result pending
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted request produced no pending result");

  // alarm and warning never latched together
  a_alarm_excludes_warning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(alarm_on_o && warning_on_o))
    else $error("alarm and warning both set");

  // obstruction only reported with no alarm held
  a_obstruct_no_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && obstructed_on_o) |-> (!alarm_on_o && !warning_on_o))
    else $error("obstruction reported with alarm or warning");

endmodule

// ----- rtl/gaa_lane.sv -----
module gaa_lane #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic [SAMPLE_WIDTH-1:0] level_i,
  input  logic [SAMPLE_WIDTH-1:0] threshold_i,
  output logic                    trigger_o
);

  // strict signed greater-than against the lane threshold
  assign trigger_o = $signed(level_i) > $signed(threshold_i);

endmodule

// ----- rtl/gaa_merge.sv -----
module gaa_merge #(
  parameter int unsigned HOLD_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             update_i,
  input  logic [HOLD_WIDTH-1:0]            hold_ticks_i,
  input  logic [gaa_pkg::MaskWidth-1:0]    trigger_mask_i,
  output gaa_pkg::gaa_result_t             result_o
);

  logic                      alarm_q, alarm_d;
  logic                      warning_q, warning_d;
  logic [HOLD_WIDTH-1:0]     hold_q, hold_d;
  gaa_pkg::led_cmd_e         last_display_q, last_display_d;

  logic [gaa_pkg::CountWidth-1:0] gas_count;
  logic                      alarm_hit;
  logic                      warn_hit;
  logic [HOLD_WIDTH-1:0]     load;
  logic                      obstructed;
  gaa_pkg::led_cmd_e         want;
  gaa_pkg::led_cmd_e         cmd;

  // number of gas lanes that fired
  assign gas_count = gaa_pkg::CountWidth'(trigger_mask_i[0])
                   + gaa_pkg::CountWidth'(trigger_mask_i[1])
                   + gaa_pkg::CountWidth'(trigger_mask_i[2])
                   + gaa_pkg::CountWidth'(trigger_mask_i[3]);

  assign alarm_hit = trigger_mask_i[gaa_pkg::LaneCo]
                  || (gas_count >= gaa_pkg::CountWidth'(gaa_pkg::MultiCount));
  assign warn_hit  = !alarm_hit && (gas_count == gaa_pkg::CountWidth'(1));

  // a zero hold time counts as one tick
  assign load = (hold_ticks_i == '0) ? HOLD_WIDTH'(1) : hold_ticks_i;

  // latch and hold counter update
  always_comb begin
    alarm_d   = alarm_q;
    warning_d = warning_q;
    hold_d    = hold_q;
    if (alarm_hit) begin
      alarm_d   = 1'b1;
      warning_d = 1'b0;
      hold_d    = load;
    end else if (warn_hit && !alarm_q) begin
      warning_d = 1'b1;
      hold_d    = load;
    end else if (hold_q != '0) begin
      hold_d = hold_q - HOLD_WIDTH'(1);
      if (hold_d == '0) begin
        alarm_d   = 1'b0;
        warning_d = 1'b0;
      end
    end
    obstructed = (gas_count == '0) && trigger_mask_i[gaa_pkg::LaneIr] && !alarm_d;
    if (obstructed) begin
      warning_d = 1'b0;
    end
  end

  // display pattern and change-only command
  always_comb begin
    if (alarm_d) begin
      want = gaa_pkg::LED_FULL;
    end else if (warning_d || obstructed) begin
      want = gaa_pkg::LED_WARN;
    end else begin
      want = gaa_pkg::LED_OFF;
    end
    cmd            = (want != last_display_q) ? want : gaa_pkg::LED_NONE;
    last_display_d = want;
  end

  // state registers, advanced once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q        <= 1'b0;
      warning_q      <= 1'b0;
      hold_q         <= '0;
      last_display_q <= gaa_pkg::LED_NONE;
    end else if (update_i) begin
      alarm_q        <= alarm_d;
      warning_q      <= warning_d;
      hold_q         <= hold_d;
      last_display_q <= last_display_d;
    end
  end

  assign result_o.alarm_on      = alarm_d;
  assign result_o.warning_on    = warning_d;
  assign result_o.obstructed_on = obstructed;
  assign result_o.trigger_mask  = trigger_mask_i;
  assign result_o.led_command   = cmd;

endmodule

// ----- bench/gaa_checker.sv -----
`timescale 1ns / 1ps

module gaa_checker
  import gaa_pkg::*;
#(
  parameter int unsigned SampleW = 16,
  parameter int unsigned HoldW   = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [IdxWidth-1:0]    cfg_index_i,
  input  logic [SampleW-1:0]     cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [SampleW-1:0]     co_level_i,
  input  logic [SampleW-1:0]     co2_level_i,
  input  logic [SampleW-1:0]     smoke_level_i,
  input  logic [SampleW-1:0]     temp_level_i,
  input  logic [SampleW-1:0]     ir_level_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   alarm_on_i,
  input  logic                   warning_on_i,
  input  logic                   obstructed_on_i,
  input  logic [MaskWidth-1:0]   trigger_mask_i,
  input  logic [1:0]             led_command_i,
  output int                     errors_o,
  output int                     pending_o
);

  // shadow of the threshold and hold registers
  logic [NumSensors-1:0][SampleW-1:0] thr_q;
  logic [HoldW-1:0]                   hold_ticks_q;

  // shadow of the alarm state
  bit               alarm_q;
  bit               warn_q;
  logic [HoldW-1:0] hold_left_q;
  led_cmd_e         shown_q;

  gaa_result_t exp_results_q[$];
  int          err_cnt = 0;

  assign errors_o = err_cnt;

  task automatic report(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    err_cnt++;
  endtask

  // one evaluation tick: compare lanes, update latches and hold counter, pick led
  function automatic gaa_result_t eval_tick(input logic [NumSensors-1:0][SampleW-1:0] lvl);
    gaa_result_t      r;
    logic [MaskWidth-1:0] hit;
    int unsigned      n_gas;
    logic [HoldW-1:0] reload;
    bit               alarm_hit;
    bit               warn_hit;
    bit               blocked;
    led_cmd_e         want;
    int               i;
    hit   = '0;
    n_gas = 0;
    for (i = 0; i < NumSensors; i++) begin
      if ($signed(lvl[i]) > $signed(thr_q[i])) hit[i] = 1'b1;
    end
    for (i = 0; i < NumGas; i++) begin
      if (hit[i]) n_gas++;
    end
    reload = (hold_ticks_q == '0) ? HoldW'(1) : hold_ticks_q;
    alarm_hit = hit[LaneCo] || (n_gas >= MultiCount);
    warn_hit  = !alarm_hit && (n_gas == 1);

    if (alarm_hit) begin
      alarm_q     = 1'b1;
      warn_q      = 1'b0;
      hold_left_q = reload;
    end else if (warn_hit && !alarm_q) begin
      warn_q      = 1'b1;
      hold_left_q = reload;
    end else if (hold_left_q != '0) begin
      hold_left_q = hold_left_q - 1'b1;
      if (hold_left_q == '0) begin
        alarm_q = 1'b0;
        warn_q  = 1'b0;
      end
    end

    // ir alone with no alarm latched means the board is covered
    blocked = (n_gas == 0) && hit[LaneIr] && !alarm_q;
    if (blocked) warn_q = 1'b0;

    if (alarm_q) begin
      want = LED_FULL;
    end else if (warn_q || blocked) begin
      want = LED_WARN;
    end else begin
      want = LED_OFF;
    end

    r.alarm_on      = alarm_q;
    r.warning_on    = warn_q;
    r.obstructed_on = blocked;
    r.trigger_mask  = hit;
    r.led_command   = LED_NONE;
    if (want != shown_q) begin
      r.led_command = want;
      shown_q       = want;
    end
    return r;
  endfunction

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    gaa_result_t want;
    if (exp_results_q.size() == 0) begin
      report("result with nothing expected", trigger_mask_i, 0);
    end else begin
      want = exp_results_q.pop_front();
      if (alarm_on_i !== want.alarm_on)
        report("alarm_on", alarm_on_i, want.alarm_on);
      if (warning_on_i !== want.warning_on)
        report("warning_on", warning_on_i, want.warning_on);
      if (obstructed_on_i !== want.obstructed_on)
        report("obstructed_on", obstructed_on_i, want.obstructed_on);
      if (trigger_mask_i !== want.trigger_mask)
        report("trigger_mask", trigger_mask_i, want.trigger_mask);
      if (led_command_i !== want.led_command)
        report("led_command", led_command_i, want.led_command);
    end
  endtask

  // watch config writes, results and requests at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        = '0;
      hold_ticks_q = HoldW'(HoldReset);
      alarm_q      = 1'b0;
      warn_q       = 1'b0;
      hold_left_q  = '0;
      shown_q      = LED_NONE;
      exp_results_q.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CO_THRESHOLD, REG_CO2_THRESHOLD, REG_SMOKE_THRESHOLD,
          REG_TEMP_THRESHOLD, REG_IR_THRESHOLD: begin
            thr_q[cfg_index_i] = cfg_data_i;
          end
          REG_HOLD_TICKS: hold_ticks_q = cfg_data_i[HoldW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        exp_results_q.push_back(eval_tick({ir_level_i, temp_level_i, smoke_level_i,
                                           co2_level_i, co_level_i}));
      end
      pending_o <= exp_results_q.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import gaa_pkg::*;

  localparam int unsigned SampleW = 16;
  localparam int unsigned HoldW   = 8;
  localparam logic [SampleW-1:0] MaxLvl = 16'h7FFF;
  localparam logic [SampleW-1:0] MinLvl = 16'h8000;
  localparam logic [SampleW-1:0] OneLvl = 16'h0001;
  localparam logic [SampleW-1:0] ZeroLvl = 16'h0000;
  localparam logic [IdxWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [IdxWidth-1:0] RegSpareHi = 3'd7;
  localparam int RxFree = 0;
  localparam int RxCoin = 1;
  localparam int NumPhases = 7;
  localparam int PhaseItems = 250;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IdxWidth-1:0] cfg_index;
  logic [SampleW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [SampleW-1:0] co_lvl, co2_lvl, smoke_lvl, temp_lvl, ir_lvl;
  logic out_valid;
  logic out_ready;
  logic alarm_on, warning_on, obstructed_on;
  logic [MaskWidth-1:0] trigger_mask;
  logic [1:0] led_command;
  int errors;
  int pending;

  // thresholds and hold as last programmed, used to aim the levels
  logic [NumSensors-1:0][SampleW-1:0] thr_sh;
  logic [HoldW-1:0] hold_sh;

  int burst_left = 0;
  int gap_max = 4;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gas_alarm_aggregator_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .co_level_i      (co_lvl),
    .co2_level_i     (co2_lvl),
    .smoke_level_i   (smoke_lvl),
    .temp_level_i    (temp_lvl),
    .ir_level_i      (ir_lvl),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .alarm_on_o      (alarm_on),
    .warning_on_o    (warning_on),
    .obstructed_on_o (obstructed_on),
    .trigger_mask_o  (trigger_mask),
    .led_command_o   (led_command)
  );

  gaa_checker #(.SampleW(SampleW), .HoldW(HoldW)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .co_level_i      (co_lvl),
    .co2_level_i     (co2_lvl),
    .smoke_level_i   (smoke_lvl),
    .temp_level_i    (temp_lvl),
    .ir_level_i      (ir_lvl),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .alarm_on_i      (alarm_on),
    .warning_on_i    (warning_on),
    .obstructed_on_i (obstructed_on),
    .trigger_mask_i  (trigger_mask),
    .led_command_i   (led_command),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // offer one request, hold it until taken, then maybe pause between bursts
  task automatic send_levels(input logic [SampleW-1:0] co, input logic [SampleW-1:0] co2,
                             input logic [SampleW-1:0] smoke, input logic [SampleW-1:0] temp,
                             input logic [SampleW-1:0] ir);
    in_valid  <= 1'b1;
    co_lvl    <= co;
    co2_lvl   <= co2;
    smoke_lvl <= smoke;
    temp_lvl  <= temp;
    ir_lvl    <= ir;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
      gap_max    = $urandom_range(1, 8);
    end
  endtask

  // wait until every expected result has been taken
  task automatic wait_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [SampleW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // program thresholds and hold, plus writes to the unused indexes
  task automatic program_regs();
    write_reg(REG_CO_THRESHOLD, thr_sh[0]);
    write_reg(REG_CO2_THRESHOLD, thr_sh[1]);
    write_reg(REG_SMOKE_THRESHOLD, thr_sh[2]);
    write_reg(REG_TEMP_THRESHOLD, thr_sh[3]);
    write_reg(REG_IR_THRESHOLD, thr_sh[4]);
    write_reg(REG_HOLD_TICKS, {8'($urandom), hold_sh});
    write_reg(RegSpareLo, 16'($urandom));
    write_reg(RegSpareHi, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // a level that lands above the threshold or at/below it (at the threshold when it is the maximum)
  function automatic logic [SampleW-1:0] pick_level(input logic [SampleW-1:0] thr,
                                                    input bit fire);
    int t;
    int v;
    t = $signed(thr);
    if (fire && t < 32767) begin
      case ($urandom_range(0, 3))
        0:       v = t + 1;
        1:       v = 32767;
        default: v = t + 1 + $urandom_range(0, 32766 - t);
      endcase
    end else if (fire) begin
      v = t;
    end else begin
      case ($urandom_range(0, 3))
        0:       v = t;
        1:       v = -32768;
        default: v = -32768 + $urandom_range(0, t + 32768);
      endcase
    end
    return v[SampleW-1:0];
  endfunction

  task automatic send_pattern(input logic [NumGas-1:0] gas, input bit ir);
    send_levels(pick_level(thr_sh[0], gas[0]), pick_level(thr_sh[1], gas[1]),
                pick_level(thr_sh[2], gas[2]), pick_level(thr_sh[3], gas[3]),
                pick_level(thr_sh[LaneIr], ir));
  endtask

  // episodes: quiet runs, single triggers, alarms, ir alone and raw noise
  task automatic run_random(input int n_items);
    int done;
    int k;
    int len;
    int j;
    int hold_eff;
    logic [NumGas-1:0] gas;
    done = 0;
    hold_eff = (hold_sh == 0) ? 1 : hold_sh;
    while (done < n_items) begin
      k = $urandom_range(0, 99);
      if (k < 30) len = $urandom_range(1, hold_eff + 3);
      else len = $urandom_range(1, 4);
      for (j = 0; j < len; j++) begin
        if (k < 30) begin
          send_pattern('0, $urandom_range(0, 3) == 0);
        end else if (k < 50) begin
          gas = 4'b0010 << $urandom_range(0, 2);
          send_pattern(gas, 1'($urandom_range(0, 1)));
        end else if (k < 70) begin
          gas = NumGas'($urandom_range(0, 15));
          if ($countones(gas) < MultiCount) gas[LaneCo] = 1'b1;
          send_pattern(gas, 1'($urandom_range(0, 1)));
        end else if (k < 80) begin
          send_pattern('0, 1'b1);
        end else begin
          send_levels(SampleW'($urandom), SampleW'($urandom), SampleW'($urandom),
                      SampleW'($urandom), SampleW'($urandom));
        end
        done++;
      end
    end
  endtask

  // receiver: stalls in segments of its own, plus a long hold-off on request
  initial begin
    int seg_left;
    int mode;
    seg_left = 0;
    mode = RxFree;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          RxFree:  out_ready <= 1'b1;
          RxCoin:  out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    int ph;
    int i;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    co_lvl    = '0;
    co2_lvl   = '0;
    smoke_lvl = '0;
    temp_lvl  = '0;
    ir_lvl    = '0;
    thr_sh    = '0;
    hold_sh   = HoldW'(HoldReset);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass on reset settings: thresholds zero, hold ten
    send_levels(ZeroLvl, ZeroLvl, ZeroLvl, ZeroLvl, ZeroLvl);  // equal is no trigger
    send_levels(MinLvl, MinLvl, MinLvl, MinLvl, MinLvl);
    send_levels(MinLvl, MinLvl, MinLvl, MinLvl, MaxLvl);      // obstructed
    send_levels(ZeroLvl, ZeroLvl, ZeroLvl, ZeroLvl, OneLvl);
    send_levels(ZeroLvl, ZeroLvl, OneLvl, ZeroLvl, ZeroLvl);  // single gas warns
    send_levels(ZeroLvl, ZeroLvl, ZeroLvl, MaxLvl, ZeroLvl);
    send_levels(ZeroLvl, OneLvl, ZeroLvl, ZeroLvl, OneLvl);   // warning beats ir
    send_levels(ZeroLvl, ZeroLvl, ZeroLvl, ZeroLvl, OneLvl);  // obstruction drops warning
    send_levels(OneLvl, ZeroLvl, ZeroLvl, ZeroLvl, ZeroLvl);  // co alone alarms
    send_levels(MinLvl, MaxLvl, OneLvl, MinLvl, MinLvl);      // two gases alarm
    send_levels(MaxLvl, MaxLvl, MaxLvl, MaxLvl, MaxLvl);
    send_levels(ZeroLvl, ZeroLvl, OneLvl, ZeroLvl, ZeroLvl);  // warning masked by alarm
    send_levels(ZeroLvl, ZeroLvl, ZeroLvl, ZeroLvl, MaxLvl);  // ir ignored under alarm
    for (i = 0; i < 9; i++) begin
      send_levels(MinLvl, ZeroLvl, MinLvl, ZeroLvl, MinLvl);  // hold runs out
    end
    send_levels(MaxLvl, MinLvl, MinLvl, MinLvl, MinLvl);

    for (ph = 0; ph < NumPhases; ph++) begin
      in_valid <= 1'b0;
      wait_drain();
      case (ph)
        0: begin thr_sh = '0; hold_sh = HoldW'(1); end
        1: begin thr_sh = {5{16'($urandom_range(0, 65535))}}; hold_sh = HoldW'(3); end
        2: begin
          thr_sh  = {MinLvl, ZeroLvl, 16'($urandom), MaxLvl, MinLvl};
          hold_sh = HoldW'(255);
        end
        3: begin
          for (i = 0; i < NumSensors; i++) thr_sh[i] = 16'($urandom);
          hold_sh = HoldW'(0);
        end
        4: begin thr_sh = {5{MinLvl}}; hold_sh = HoldW'(2); end
        5: begin thr_sh = {5{MaxLvl}}; hold_sh = HoldW'(7); end
        default: begin
          for (i = 0; i < NumSensors; i++) thr_sh[i] = 16'($urandom_range(0, 1023)) - 16'd512;
          hold_sh = HoldW'($urandom_range(1, 20));
        end
      endcase
      program_regs();
      if (ph == 1) stall_left = 80;
      run_random(PhaseItems);
    end

    in_valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[gas_alarm_aggregator_unit] OK");
    end else begin
      $display("[gas_alarm_aggregator_unit] ERROR");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #5000000;
    $display("[gas_alarm_aggregator_unit] ERROR");
    $finish;
  end

endmodule
